// File: rtl/core/pew_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pew_pkg
// Shared widths, register indexes, reset values and the particle state type
// for the particle Euler step with reflecting walls.
// ----------------------------------------------------------------------------
package pew_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DT_SHIFT  = 24;

    localparam int DT_W   = 18;
    localparam int GRAV_W = 21;
    localparam int POS_W  = 23;
    localparam int VEL_W  = 24;
    localparam int CFG_W  = 23;
    localparam int IDX_W  = 2;

    // square root datapath
    localparam int SQ_W   = 2 * VEL_W;
    localparam int ACC_W  = SQ_W + 1;
    localparam int ROOT_W = VEL_W;
    localparam int ITERS  = SQ_W / 2;

    localparam logic [IDX_W-1:0] REG_TIME_STEP    = 2'd0;
    localparam logic [IDX_W-1:0] REG_GRAVITY_PULL = 2'd1;
    localparam logic [IDX_W-1:0] REG_BOX_SIZE     = 2'd2;

    localparam logic [DT_W-1:0]   TIME_STEP_RST    = 18'd67109;
    localparam logic [GRAV_W-1:0] GRAVITY_PULL_RST = 21'd0;
    localparam logic [POS_W-1:0]  BOX_SIZE_RST     = POS_W'(100 << FRAC_BITS);

    typedef struct packed {
        logic [POS_W-1:0]        new_x;
        logic [POS_W-1:0]        new_y;
        logic signed [VEL_W-1:0] new_vx;
        logic signed [VEL_W-1:0] new_vy;
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]        pos;
        logic signed [VEL_W-1:0] vel;
    } axis_t;

endpackage

// File: rtl/core/pew_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pew_isqrt
// Pipelined integer square root, one result bit per stage, rounded to
// nearest in a final output stage. The particle state rides alongside.
// ----------------------------------------------------------------------------
module pew_isqrt (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [pew_pkg::SQ_W-1:0]  in_sq,
    input  pew_pkg::state_t           in_side,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [pew_pkg::ROOT_W-1:0] out_root,
    output pew_pkg::state_t           out_side
);
    import pew_pkg::*;

    localparam int N = ITERS;

    logic [N:0]         vld_reg;
    logic [N+1:0]       rdy;
    logic [N-1:0]       vld_src;
    logic [ACC_W-1:0]   rem_reg  [N];
    logic [ACC_W-1:0]   root_reg [N];
    state_t             side_reg [N+1];
    logic [ACC_W-1:0]   rem_src  [N];
    logic [ACC_W-1:0]   root_src [N];
    state_t             side_src [N];
    logic [ROOT_W-1:0]  root_out_reg;
    logic [ACC_W-1:0]   root_next;

    assign rdy[N+1] = out_ready;
    assign in_ready = rdy[0];

    genvar k;
    generate
        for (k = 0; k <= N; k++) begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end

        for (k = 0; k < N; k++) begin : g_stage
            localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (N - 1 - k));
            logic [ACC_W-1:0] trial;
            logic             ge;

            if (k == 0) begin : g_first
                assign rem_src[k]  = {1'b0, in_sq};
                assign root_src[k] = '0;
                assign side_src[k] = in_side;
                assign vld_src[k]  = in_valid;
            end else begin : g_rest
                assign rem_src[k]  = rem_reg[k-1];
                assign root_src[k] = root_reg[k-1];
                assign side_src[k] = side_reg[k-1];
                assign vld_src[k]  = vld_reg[k-1];
            end

            assign trial = root_src[k] + BIT;
            assign ge    = rem_src[k] >= trial;

            always_ff @(posedge aclk) begin
                if (rdy[k]) begin
                    rem_reg[k]  <= ge ? rem_src[k] - trial : rem_src[k];
                    root_reg[k] <= ge ? (root_src[k] >> 1) + BIT : root_src[k] >> 1;
                    side_reg[k] <= side_src[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    vld_reg[k] <= 1'b0;
                end else if (rdy[k]) begin
                    vld_reg[k] <= vld_src[k];
                end
            end
        end
    endgenerate

    // round to nearest
    assign root_next = root_reg[N-1] + ACC_W'(rem_reg[N-1] > root_reg[N-1]);

    always_ff @(posedge aclk) begin
        if (rdy[N]) begin
            root_out_reg <= root_next[ROOT_W-1:0];
            side_reg[N]  <= side_reg[N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[N] <= 1'b0;
        end else if (rdy[N]) begin
            vld_reg[N] <= vld_reg[N-1];
        end
    end

    assign out_valid = vld_reg[N];
    assign out_root  = root_out_reg;
    assign out_side  = side_reg[N];

endmodule

// File: rtl/core/particle_euler_wall_reflect.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// particle_euler_wall_reflect
// One Euler step of a particle in a square box with reflecting walls, plus
// the rounded speed of the new velocity.
// ----------------------------------------------------------------------------
// pipeline: 7 step stages, 24 root stages, one rounding stage
// throughput: one request per cycle unless m_ready stalls; each stage holds its
// own valid bit, so a stalled output only stops stages that are full
// reset: synchronous active-low; clears all valid bits and loads the register
// defaults (time_step 67109, gravity_pull 0, box_size 100.0)
module particle_euler_wall_reflect (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [pew_pkg::IDX_W-1:0]         cfg_index,
    input  logic [pew_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [pew_pkg::POS_W-1:0]         s_pos_x,
    input  logic [pew_pkg::POS_W-1:0]         s_pos_y,
    input  logic signed [pew_pkg::VEL_W-1:0]  s_vel_x,
    input  logic signed [pew_pkg::VEL_W-1:0]  s_vel_y,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [pew_pkg::POS_W-1:0]         m_new_x,
    output logic [pew_pkg::POS_W-1:0]         m_new_y,
    output logic signed [pew_pkg::VEL_W-1:0]  m_new_vx,
    output logic signed [pew_pkg::VEL_W-1:0]  m_new_vy,
    output logic [pew_pkg::ROOT_W-1:0]        m_speed_mag
);
    import pew_pkg::*;

    localparam int NST    = 7;
    localparam int PV_W   = VEL_W + DT_W + 1;
    localparam int PG_W   = GRAV_W + DT_W;
    localparam int DV_W   = PV_W - DT_SHIFT;
    localparam int DG_W   = PG_W + 1 - DT_SHIFT;
    localparam int PE_W   = POS_W + 2;
    localparam int VSQ_W  = SQ_W - 1;
    localparam logic [PV_W-1:0] RND_V = PV_W'(1) << (DT_SHIFT - 1);
    localparam logic [PG_W:0]   RND_G = (PG_W + 1)'(1) << (DT_SHIFT - 1);

    function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [VEL_W:0] v);
        logic signed [VEL_W-1:0] r;
        if (v[VEL_W] != v[VEL_W-1]) begin
            r = v[VEL_W] ? {1'b1, {(VEL_W-1){1'b0}}} : {1'b0, {(VEL_W-1){1'b1}}};
        end else begin
            r = v[VEL_W-1:0];
        end
        return r;
    endfunction

    function automatic axis_t reflect_axis(input logic signed [PE_W-1:0] p,
                                           input logic signed [VEL_W-1:0] v,
                                           input logic [POS_W-1:0] b);
        logic signed [PE_W:0]  pe;
        logic signed [PE_W:0]  bs;
        logic signed [PE_W:0]  pm;
        logic signed [VEL_W:0] vn;
        axis_t                 r;
        pe = (PE_W + 1)'(p);
        bs = $signed({3'b000, b});
        vn = -(VEL_W + 1)'(v);
        if (pe < 0) begin
            pm    = -pe;
            r.vel = sat_vel(vn);
        end else if (pe > bs) begin
            pm    = (bs <<< 1) - pe;
            r.vel = sat_vel(vn);
        end else begin
            pm    = pe;
            r.vel = v;
        end
        // still outside after one mirror
        if (pm < 0) begin
            r.pos = '0;
        end else if (pm > bs) begin
            r.pos = b;
        end else begin
            r.pos = pm[POS_W-1:0];
        end
        return r;
    endfunction

    // configuration registers
    logic [DT_W-1:0]   time_step_reg;
    logic [GRAV_W-1:0] gravity_pull_reg;
    logic [POS_W-1:0]  box_size_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg    <= TIME_STEP_RST;
            gravity_pull_reg <= GRAVITY_PULL_RST;
            box_size_reg     <= BOX_SIZE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_TIME_STEP:    time_step_reg    <= cfg_wdata[DT_W-1:0];
                REG_GRAVITY_PULL: gravity_pull_reg <= cfg_wdata[GRAV_W-1:0];
                REG_BOX_SIZE:     box_size_reg     <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // stage handshake
    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;
    logic           root_in_ready;

    assign s_ready  = rdy[0];

    always_comb begin
        rdy[NST] = root_in_ready;
        for (int i = NST - 1; i >= 0; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (rdy[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // stage 1: products with dt
    logic [POS_W-1:0]        x1_reg, y1_reg;
    logic signed [VEL_W-1:0] vx1_reg, vy1_reg;
    logic signed [PV_W-1:0]  pvx1_reg, pvx_next;
    logic [PG_W-1:0]         pg1_reg, pg_next;

    assign pvx_next = s_vel_x * $signed({1'b0, time_step_reg});
    assign pg_next  = gravity_pull_reg * time_step_reg;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            x1_reg   <= s_pos_x;
            y1_reg   <= s_pos_y;
            vx1_reg  <= s_vel_x;
            vy1_reg  <= s_vel_y;
            pvx1_reg <= pvx_next;
            pg1_reg  <= pg_next;
        end
    end

    // stage 2: round, gravity, move x
    logic signed [PV_W-1:0]  pvx_rnd;
    logic [PG_W:0]           pg_rnd;
    logic signed [DV_W-1:0]  dx;
    logic [DG_W-1:0]         dg;
    logic signed [PE_W-1:0]  x2_next, x2_reg;
    logic signed [VEL_W-1:0] vy2_next, vy2_reg, vx2_reg;
    logic [POS_W-1:0]        y2_reg;

    assign pvx_rnd  = pvx1_reg + $signed(RND_V);
    assign dx       = pvx_rnd[PV_W-1:DT_SHIFT];
    assign pg_rnd   = {1'b0, pg1_reg} + RND_G;
    assign dg       = pg_rnd[PG_W:DT_SHIFT];
    assign vy2_next = sat_vel((VEL_W + 1)'(vy1_reg) + $signed({{(VEL_W + 1 - DG_W){1'b0}}, dg}));
    assign x2_next  = $signed({2'b00, x1_reg}) + PE_W'(dx);

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            x2_reg  <= x2_next;
            y2_reg  <= y1_reg;
            vx2_reg <= vx1_reg;
            vy2_reg <= vy2_next;
        end
    end

    // stage 3: vy times dt, reflect x
    logic signed [PV_W-1:0]  pvy3_reg, pvy_next;
    axis_t                   ax3_next, ax3_reg;
    logic [POS_W-1:0]        y3_reg;
    logic signed [VEL_W-1:0] vy3_reg;

    assign pvy_next = vy2_reg * $signed({1'b0, time_step_reg});
    assign ax3_next = reflect_axis(x2_reg, vx2_reg, box_size_reg);

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            pvy3_reg <= pvy_next;
            ax3_reg  <= ax3_next;
            y3_reg   <= y2_reg;
            vy3_reg  <= vy2_reg;
        end
    end

    // stage 4: move y
    logic signed [PV_W-1:0]  pvy_rnd;
    logic signed [DV_W-1:0]  dy;
    logic signed [PE_W-1:0]  y4_next, y4_reg;
    axis_t                   ax4_reg;
    logic signed [VEL_W-1:0] vy4_reg;

    assign pvy_rnd = pvy3_reg + $signed(RND_V);
    assign dy      = pvy_rnd[PV_W-1:DT_SHIFT];
    assign y4_next = $signed({2'b00, y3_reg}) + PE_W'(dy);

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            y4_reg  <= y4_next;
            ax4_reg <= ax3_reg;
            vy4_reg <= vy3_reg;
        end
    end

    // stage 5: reflect y
    axis_t ax5_reg, ay5_reg, ay5_next;

    assign ay5_next = reflect_axis(y4_reg, vy4_reg, box_size_reg);

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            ax5_reg <= ax4_reg;
            ay5_reg <= ay5_next;
        end
    end

    // stage 6: squares
    logic signed [SQ_W-1:0] sqx_next, sqy_next;
    logic [VSQ_W-1:0]       sqx6_reg, sqy6_reg;
    state_t                 st6_reg;

    assign sqx_next = ax5_reg.vel * ax5_reg.vel;
    assign sqy_next = ay5_reg.vel * ay5_reg.vel;

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            sqx6_reg       <= sqx_next[VSQ_W-1:0];
            sqy6_reg       <= sqy_next[VSQ_W-1:0];
            st6_reg.new_x  <= ax5_reg.pos;
            st6_reg.new_y  <= ay5_reg.pos;
            st6_reg.new_vx <= ax5_reg.vel;
            st6_reg.new_vy <= ay5_reg.vel;
        end
    end

    // stage 7: sum of squares
    logic [SQ_W-1:0] sum7_reg;
    state_t          st7_reg;

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            sum7_reg <= {1'b0, sqx6_reg} + {1'b0, sqy6_reg};
            st7_reg  <= st6_reg;
        end
    end

    state_t out_side;

    pew_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vld_reg[NST-1]),
        .in_ready  (root_in_ready),
        .in_sq     (sum7_reg),
        .in_side   (st7_reg),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_root  (m_speed_mag),
        .out_side  (out_side)
    );

    assign m_new_x  = out_side.new_x;
    assign m_new_y  = out_side.new_y;
    assign m_new_vx = out_side.new_vx;
    assign m_new_vy = out_side.new_vy;

endmodule
